// ----- src/tswb_pkg.sv -----
// Shared types and constants for the timestamped sample window buffer.
// No dependencies; used by every module in src/.
package tswb_pkg;

  localparam int unsigned DEPTH   = 32;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned TIME_W  = 53;
  localparam int unsigned PAY_W   = 48;
  localparam int unsigned TOL_W   = 10;
  localparam int unsigned QDEPTH  = 2;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_PRUNE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_NEWER = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_RANGE = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_START_UNC = 3'd5;
  localparam logic [2:0] ST_END_UNC   = 3'd6;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_QUERY,
    OP_PRUNE,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [TIME_W-1:0] time_value;
    logic [TIME_W-1:0] range_end;
    logic [PAY_W-1:0]  payload;
  } in_req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              has_sample;
    logic [TIME_W-1:0] sample_time;
    logic [PAY_W-1:0]  sample_payload;
    logic              last;
    logic [5:0]        entry_count;
  } out_req_t;

  typedef struct packed {
    op_e               op;
    logic [TIME_W-1:0] time_value;
    logic [TIME_W-1:0] range_end;
    logic [PAY_W-1:0]  payload;
  } job_t;

endpackage

// ----- src/tswb_front.sv -----
// Front end: accepts requests, decodes the command, and queues jobs.
// Depends on tswb_pkg.
module tswb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tswb_pkg::in_req_t in_req_i,
  output logic             job_valid_o,
  input  logic             job_pop_i,
  output tswb_pkg::job_t   job_o
);

  localparam int unsigned PW = $clog2(tswb_pkg::QDEPTH);

  tswb_pkg::job_t       q_mem [tswb_pkg::QDEPTH];
  logic [PW-1:0]        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PW:0]          cnt_q, cnt_d;
  logic                 push, pop;
  tswb_pkg::job_t       job_in;

  always_comb begin
    job_in.time_value = in_req_i.time_value;
    job_in.range_end  = in_req_i.range_end;
    job_in.payload    = in_req_i.payload;
    case (in_req_i.command)
      tswb_pkg::CMD_PUSH:  job_in.op = tswb_pkg::OP_PUSH;
      tswb_pkg::CMD_QUERY: job_in.op = tswb_pkg::OP_QUERY;
      tswb_pkg::CMD_PRUNE: job_in.op = tswb_pkg::OP_PRUNE;
      default:             job_in.op = tswb_pkg::OP_NOP;
    endcase
  end

  assign in_stall_o  = (cnt_q == (PW+1)'(tswb_pkg::QDEPTH));
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = job_pop_i && job_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= job_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- src/tswb_back.sv -----
// Back end: sample store, command sequencer and result register.
// Depends on tswb_pkg.
module tswb_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [tswb_pkg::TOL_W-1:0]       tol_i,
  input  logic                             job_valid_i,
  output logic                             job_pop_o,
  input  tswb_pkg::job_t                   job_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output tswb_pkg::out_req_t               out_req_o
);

  localparam int unsigned IW = tswb_pkg::IDX_W;
  localparam int unsigned CW = tswb_pkg::CNT_W;
  localparam int unsigned TW = tswb_pkg::TIME_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_QOLD   = 4'd2;
  localparam logic [3:0] S_SRD    = 4'd3;
  localparam logic [3:0] S_SCHK   = 4'd4;
  localparam logic [3:0] S_ERD    = 4'd5;
  localparam logic [3:0] S_EOUT   = 4'd6;
  localparam logic [3:0] S_PRD    = 4'd7;
  localparam logic [3:0] S_PCHK   = 4'd8;
  localparam logic [3:0] S_RES    = 4'd9;

  logic [TW-1:0]              time_mem [tswb_pkg::DEPTH];
  logic [tswb_pkg::PAY_W-1:0] pay_mem  [tswb_pkg::DEPTH];

  logic [3:0]     state_q, state_d;
  tswb_pkg::job_t job_q, job_d;
  logic [IW-1:0]  head_q, head_d;
  logic [CW-1:0]  count_q, count_d;
  logic [TW-1:0]  newest_q, newest_d;
  logic [CW-1:0]  k_q, k_d;
  logic [CW-1:0]  first_q, first_d;
  logic [2:0]     status_q, status_d;

  logic [TW-1:0]              rtime_q;
  logic [tswb_pkg::PAY_W-1:0] rpay_q;
  logic                       rd_en;
  logic [CW-1:0]              rd_off;
  logic [IW-1:0]              rd_addr, wr_addr;
  logic                       wr_en;

  logic                out_valid_q;
  tswb_pkg::out_req_t  out_q, out_d;
  logic                out_free, out_load;

  logic [TW:0]    start_tol, newest_tol;
  logic           fin;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(k);
    if (s >= (CW+1)'(tswb_pkg::DEPTH)) begin
      s = s - (CW+1)'(tswb_pkg::DEPTH);
    end
    return s[IW-1:0];
  endfunction

  assign out_free   = !out_valid_q || !out_stall_i;
  assign start_tol  = {1'b0, job_q.time_value} + (TW+1)'(tol_i);
  assign newest_tol = {1'b0, newest_q} + (TW+1)'(tol_i);
  assign rd_addr    = slot(head_q, rd_off);
  assign wr_addr    = slot(head_q, count_q);
  assign fin        = (rtime_q >= job_q.range_end) || (k_q + CW'(1) == count_q);

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    head_d    = head_q;
    count_d   = count_q;
    newest_d  = newest_q;
    k_d       = k_q;
    first_d   = first_q;
    status_d  = status_q;
    job_pop_o = 1'b0;
    rd_en     = 1'b0;
    rd_off    = k_q;
    wr_en     = 1'b0;
    out_load  = 1'b0;
    out_d     = '0;

    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          state_d   = S_DEC;
        end
      end
      S_DEC: begin
        status_d = tswb_pkg::ST_OK;
        state_d  = S_RES;
        case (job_q.op)
          tswb_pkg::OP_PUSH: begin
            if (count_q != '0 && job_q.time_value <= newest_q) begin
              status_d = tswb_pkg::ST_NOT_NEWER;
            end else if (count_q == CW'(tswb_pkg::DEPTH)) begin
              status_d = tswb_pkg::ST_FULL;
            end else begin
              wr_en    = 1'b1;
              newest_d = job_q.time_value;
              count_d  = count_q + CW'(1);
            end
          end
          tswb_pkg::OP_QUERY: begin
            if (job_q.time_value >= job_q.range_end) begin
              status_d = tswb_pkg::ST_BAD_RANGE;
            end else if (count_q == '0) begin
              status_d = tswb_pkg::ST_EMPTY;
            end else begin
              rd_en   = 1'b1;
              rd_off  = '0;
              state_d = S_QOLD;
            end
          end
          tswb_pkg::OP_PRUNE: begin
            if (count_q > CW'(1)) begin
              state_d = S_PRD;
            end
          end
          default: ;
        endcase
      end
      S_QOLD: begin
        if ({1'b0, rtime_q} > start_tol) begin
          status_d = tswb_pkg::ST_START_UNC;
          state_d  = S_RES;
        end else if (newest_tol < {1'b0, job_q.range_end}) begin
          status_d = tswb_pkg::ST_END_UNC;
          state_d  = S_RES;
        end else begin
          k_d     = '0;
          first_d = '0;
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        rd_en   = 1'b1;
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (rtime_q <= job_q.time_value) begin
          first_d = k_q;
          if (k_q + CW'(1) < count_q) begin
            k_d     = k_q + CW'(1);
            state_d = S_SRD;
          end else begin
            k_d     = k_q;
            state_d = S_ERD;
          end
        end else begin
          k_d     = first_q;
          state_d = S_ERD;
        end
      end
      S_ERD: begin
        rd_en   = 1'b1;
        state_d = S_EOUT;
      end
      S_EOUT: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_d.status         = tswb_pkg::ST_OK;
          out_d.has_sample     = 1'b1;
          out_d.sample_time    = rtime_q;
          out_d.sample_payload = rpay_q;
          out_d.last           = fin;
          out_d.entry_count    = 6'(count_q);
          if (fin) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + CW'(1);
            state_d = S_ERD;
          end
        end
      end
      S_PRD: begin
        rd_en   = 1'b1;
        rd_off  = CW'(1);
        state_d = S_PCHK;
      end
      S_PCHK: begin
        if (rtime_q <= job_q.time_value) begin
          head_d  = slot(head_q, CW'(1));
          count_d = count_q - CW'(1);
          state_d = (count_q > CW'(2)) ? S_PRD : S_RES;
        end else begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.status      = status_q;
          out_d.last        = 1'b1;
          out_d.entry_count = 6'(count_q);
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sample store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      time_mem[wr_addr] <= job_q.time_value;
      pay_mem[wr_addr]  <= job_q.payload;
    end
    if (rd_en) begin
      rtime_q <= time_mem[rd_addr];
      rpay_q  <= pay_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    newest_q <= newest_d;
    k_q      <= k_d;
    first_q  <= first_d;
    status_q <= status_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(tswb_pkg::DEPTH))
    else $error("held count exceeds depth");

  a_sample_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.has_sample |-> out_q.status == tswb_pkg::ST_OK)
    else $error("sample result with failing status");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> count_q == $past(count_q) + CW'(1))
    else $error("accepted push did not grow the store");

  a_one_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> state_q == S_IDLE)
    else $error("job taken while busy");

endmodule

// ----- src/timestamped_sample_window_buffer_top.sv -----
// Top level of the timestamped sample window buffer.
// Depends on tswb_pkg, tswb_front and tswb_back.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------
//  in      | input     | in_valid_i / in_stall_o  | in_req_i  (in_req_t)
//  out     | output    | out_valid_o / out_stall_i| out_req_o (out_req_t)
//  cfg     | input     | cfg_we_i                 | cfg_wdata_i (tolerance)
//
// One request is worked at a time. A push, a prune that checks nothing, or
// a query refused on its range or an empty store passes take, decide and
// result; a query refused on coverage also passes the oldest-entry check.
// A prune reads and checks entries one by one; a query checks the oldest
// entry, then scans entries for the start and emits samples one by one,
// each through the single registered read port of the sample store.
// A two-entry job queue lets new requests in while the back end is busy
// or its result register waits on out_stall_i.
// Reset empties the store (no clearing pass) and sets the tolerance to 1.
module timestamped_sample_window_buffer_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  tswb_pkg::in_req_t          in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output tswb_pkg::out_req_t         out_req_o,
  input  logic                       cfg_we_i,
  input  logic [tswb_pkg::TOL_W-1:0] cfg_wdata_i
);

  logic [tswb_pkg::TOL_W-1:0] tol_q;
  logic                       job_valid, job_pop;
  tswb_pkg::job_t             job;

  // boundary tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= tswb_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  tswb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .job_valid_o (job_valid),
    .job_pop_i   (job_pop),
    .job_o       (job)
  );

  tswb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_i       (tol_q),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
